// ===== rtl/pmsu_pkg.sv =====
package pmsu_pkg;

  localparam int SIDE       = 16;
  localparam int NUM_STATES = 3;
  localparam int SITES      = SIDE * SIDE;
  localparam int CPL_DEPTH  = 2 * SITES * NUM_STATES * NUM_STATES;

  localparam int SIDE_W  = $clog2(SIDE);
  localparam int SITE_W  = $clog2(SITES);
  localparam int CADDR_W = $clog2(CPL_DEPTH);

  localparam int LUT_DEPTH = 256;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  // APB byte address of the beta_coupling register
  localparam logic [1:0] ADDR_BETA = 2'd0;

  typedef enum logic [1:0] {
    REQ_TRIAL     = 2'd0,
    REQ_WR_SPIN   = 2'd1,
    REQ_WR_CPL    = 2'd2,
    REQ_RD_SPIN   = 2'd3
  } req_e;

  typedef logic [15:0] exp_lut_t [LUT_DEPTH];

  // exp(-i/16) in Q0.16, evaluated at elaboration
  function automatic exp_lut_t build_exp_lut();
    exp_lut_t    lut;
    logic [63:0] e;
    logic [63:0] q;
    e = 64'd1 << 32;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      if (i > 0) e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      q = (e + (64'd1 << 15)) >> 16;
      lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return lut;
  endfunction

  localparam exp_lut_t EXP_LUT = build_exp_lut();

endpackage

// ===== rtl/potts_metropolis_site_update_unit.sv =====
// Potts lattice with a Metropolis single-site update. Requests are taken on
// start_i while busy_o is low; each yields exactly one result, shown for a
// single cycle with result_valid_o, and the receiver cannot stall it. Spins
// and couplings sit in memories with one registered read port, so the five
// spin reads and eight coupling reads of a trial go one per cycle, each run
// followed by a read-latency wait state, then a multiply state and a
// lookup/write-back state. Lattice and couplings power up undefined and must
// be loaded before trials.
module potts_metropolis_site_update_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic        bond_dir_i,
  input  logic [2:0]  first_state_i,
  input  logic [2:0]  second_state_i,
  input  logic signed [15:0] coupling_value_i,
  input  logic [2:0]  spin_value_i,
  input  logic [15:0] random_fraction_i,
  output logic        result_valid_o,
  output logic        accepted_o,
  output logic [2:0]  site_spin_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = pmsu_pkg::SIDE_W;
  localparam int AW = pmsu_pkg::CADDR_W;
  localparam int NS = pmsu_pkg::NUM_STATES;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SPIN, ST_SWAIT, ST_CPL, ST_CWAIT, ST_MUL, ST_DONE
  } state_e;

  state_e state_q;
  logic [2:0] step_q;

  // config
  logic [15:0] beta_q;
  assign pready = 1'b1;
  assign prdata = {16'b0, beta_q};

  // captured request
  logic [1:0]  req_q;
  logic [SW-1:0] r_q, c_q;
  logic        dir_q;
  logic [2:0]  fs_q, ss_q, sv_q;
  logic [15:0] cv_q, rnd_q;

  // memories
  logic [2:0]  spin_mem [pmsu_pkg::SITES];
  logic [15:0] cpl_mem  [pmsu_pkg::CPL_DEPTH];
  logic [2:0]  spin_rd_q;
  logic [15:0] cpl_rd_q;

  // spins: self, r+1, r-1, c+1, c-1
  logic [2:0]  spin_q [5];
  logic        rvld_q;
  logic [2:0]  rtag_q;
  logic signed [18:0] d_q;
  logic [33:0] p_q;

  logic [pmsu_pkg::SITE_W-1:0] spin_addr;
  logic [AW-1:0] cpl_addr;
  logic [AW-1:0] wr_cpl_addr;
  logic          sv_ok;
  logic          trial;
  logic [1:0]    k;
  logic [SW-1:0] br, bc;
  logic          bdir;
  logic [2:0]    own_s, nb_s;
  logic [7:0]    lut_idx;
  logic          acc;

  assign busy_o = (state_q != ST_IDLE);
  assign sv_ok  = (sv_q < 3'(NS));
  assign trial  = (req_q == pmsu_pkg::REQ_TRIAL);

  always_comb begin
    case (step_q)
      3'd1:    spin_addr = {r_q + SW'(1), c_q};
      3'd2:    spin_addr = {r_q - SW'(1), c_q};
      3'd3:    spin_addr = {r_q, c_q + SW'(1)};
      3'd4:    spin_addr = {r_q, c_q - SW'(1)};
      default: spin_addr = {r_q, c_q};
    endcase
  end

  // coupling read: step[2:1] picks the bond, step[0] old/new own state
  always_comb begin
    k = step_q[2:1];
    case (k)
      2'd0: begin br = r_q;         bc = c_q;         bdir = 1'b0; end
      2'd1: begin br = r_q - SW'(1); bc = c_q;        bdir = 1'b0; end
      2'd2: begin br = r_q;         bc = c_q;         bdir = 1'b1; end
      default: begin br = r_q;      bc = c_q - SW'(1); bdir = 1'b1; end
    endcase
    nb_s  = spin_q[3'(k) + 3'd1];
    own_s = (step_q[0] && sv_ok) ? sv_q : spin_q[0];
    cpl_addr = AW'({bdir, br, bc}) * AW'(NS * NS) + AW'(own_s) * AW'(NS) + AW'(nb_s);
    wr_cpl_addr = AW'({dir_q, r_q, c_q}) * AW'(NS * NS) + AW'(fs_q) * AW'(NS) + AW'(ss_q);
  end

  always_comb begin
    lut_idx = (p_q[33:24] != '0) ? 8'hFF : p_q[23:16];
    acc = trial && sv_ok && ((d_q <= 0) || (pmsu_pkg::EXP_LUT[lut_idx] > rnd_q));
  end

  always_ff @(posedge clk_i) begin
    spin_rd_q <= spin_mem[spin_addr];
    cpl_rd_q  <= cpl_mem[cpl_addr];
    if (state_q == ST_DONE) begin
      if (acc || (req_q == pmsu_pkg::REQ_WR_SPIN && sv_ok)) spin_mem[{r_q, c_q}] <= sv_q;
      if (req_q == pmsu_pkg::REQ_WR_CPL && fs_q < 3'(NS) && ss_q < 3'(NS))
        cpl_mem[wr_cpl_addr] <= cv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      rvld_q         <= 1'b0;
      result_valid_o <= 1'b0;
      beta_q         <= 16'd5120;
    end else begin
      result_valid_o <= 1'b0;
      if (psel && penable && pwrite && pready && paddr == pmsu_pkg::ADDR_BETA)
        beta_q <= pwdata[15:0];
      rvld_q <= (state_q == ST_SPIN);
      rtag_q <= step_q;
      if (rvld_q) spin_q[rtag_q] <= spin_rd_q;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            req_q  <= req_type_i;
            r_q    <= row_i[SW-1:0];
            c_q    <= col_i[SW-1:0];
            dir_q  <= bond_dir_i;
            fs_q   <= first_state_i;
            ss_q   <= second_state_i;
            cv_q   <= coupling_value_i;
            sv_q   <= spin_value_i;
            rnd_q  <= random_fraction_i;
            step_q <= '0;
            state_q <= ST_SPIN;
          end
        end
        ST_SPIN: begin
          if (!trial || step_q == 3'd4) state_q <= ST_SWAIT;
          else step_q <= step_q + 3'd1;
        end
        ST_SWAIT: begin
          step_q <= '0;
          d_q    <= '0;
          state_q <= trial ? ST_CPL : ST_DONE;
        end
        ST_CPL: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) state_q <= ST_CWAIT;
        end
        ST_CWAIT: state_q <= ST_MUL;
        ST_MUL: begin
          p_q <= 34'(d_q[17:0]) * 34'(beta_q);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          result_valid_o <= 1'b1;
          accepted_o     <= acc;
          if (acc || (req_q == pmsu_pkg::REQ_WR_SPIN && sv_ok)) site_spin_o <= sv_q;
          else site_spin_o <= spin_q[0];
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      // accumulate old minus new in the cycle after each coupling read
      if (state_q == ST_CPL && step_q != 3'd0 || state_q == ST_CWAIT) begin
        if (step_q[0]) d_q <= d_q + 19'(signed'(cpl_rd_q));
        else           d_q <= d_q - 19'(signed'(cpl_rd_q));
      end
    end
  end

endmodule

// ===== tb/sv/tb_potts_metropolis_site_update_unit.sv =====
`timescale 1ns / 1ps

module tb_potts_metropolis_site_update_unit;

  localparam int SIDE       = pmsu_pkg::SIDE;
  localparam int SITES      = pmsu_pkg::SITES;
  localparam int NUM_STATES = pmsu_pkg::NUM_STATES;
  localparam int CPL_DEPTH  = pmsu_pkg::CPL_DEPTH;

  typedef struct {
    pmsu_pkg::req_e kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        dir;
    logic [2:0]  own_st;
    logic [2:0]  nbr_st;
    logic [15:0] cpl;
    logic [2:0]  spin;
    logic [15:0] frac;
  } site_req_t;

  typedef struct {
    logic       acc;
    logic [2:0] spin;
  } site_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = '0;
  logic [5:0]  row_i = '0;
  logic [5:0]  col_i = '0;
  logic        bond_dir_i = 1'b0;
  logic [2:0]  first_state_i = '0;
  logic [2:0]  second_state_i = '0;
  logic signed [15:0] coupling_value_i = '0;
  logic [2:0]  spin_value_i = '0;
  logic [15:0] random_fraction_i = '0;
  logic        result_valid_o;
  logic        accepted_o;
  logic [2:0]  site_spin_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  potts_metropolis_site_update_unit uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // golden state
  logic [2:0]  lat_mdl [SITES];
  logic [15:0] cpl_mdl [CPL_DEPTH];
  logic [15:0] beta_mdl = 16'd5120;
  logic [15:0] exp_q16 [256];

  site_req_t pending_reqs[$];
  site_res_t expected_results[$];
  site_req_t cur_req;
  bit        hold_off = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        errors = 0;
  longint    cycles = 0;

  function automatic int site_of(int r, int c);
    return (r % SIDE) * SIDE + (c % SIDE);
  endfunction

  function automatic int bond_j(int dir, int site, int a, int b);
    return int'($signed(cpl_mdl[((dir * SITES + site) * NUM_STATES + a) * NUM_STATES + b]));
  endfunction

  function automatic int bond_sum(int r, int c, int s);
    int rp, rm, cp, cm;
    rp = (r + 1) % SIDE;
    rm = (r + SIDE - 1) % SIDE;
    cp = (c + 1) % SIDE;
    cm = (c + SIDE - 1) % SIDE;
    return bond_j(0, site_of(r, c), s, lat_mdl[site_of(rp, c)] % NUM_STATES)
         + bond_j(0, site_of(rm, c), s, lat_mdl[site_of(rm, c)] % NUM_STATES)
         + bond_j(1, site_of(r, c), s, lat_mdl[site_of(r, cp)] % NUM_STATES)
         + bond_j(1, site_of(r, cm), s, lat_mdl[site_of(r, cm)] % NUM_STATES);
  endfunction

  // rows/cols -1..4 of the lattice (aliased up to 63): every spin there is loaded
  function automatic int win_coord();
    return (($urandom_range(0, 5) + SIDE - 1) % SIDE) + SIDE * $urandom_range(0, 3);
  endfunction

  // rows/cols 0..3: all neighbors and bonds of a trial here are loaded
  function automatic int trial_coord();
    return $urandom_range(0, 3) + SIDE * $urandom_range(0, 3);
  endfunction

  task automatic predict_site_update(site_req_t q);
    int        r, c, site, d, old_s;
    longint    idx;
    site_res_t res;
    r = q.row % SIDE;
    c = q.col % SIDE;
    site = site_of(r, c);
    res.acc = 1'b0;
    case (q.kind)
      pmsu_pkg::REQ_TRIAL: begin
        if (q.spin < NUM_STATES) begin
          old_s = lat_mdl[site] % NUM_STATES;
          d = bond_sum(r, c, old_s) - bond_sum(r, c, q.spin);
          if (d <= 0) res.acc = 1'b1;
          else begin
            idx = (longint'(d) * beta_mdl) >>> 16;
            if (idx > 255) idx = 255;
            res.acc = exp_q16[idx] > q.frac;
          end
          if (res.acc) lat_mdl[site] = q.spin;
        end
      end
      pmsu_pkg::REQ_WR_SPIN: begin
        if (q.spin < NUM_STATES) lat_mdl[site] = q.spin;
      end
      pmsu_pkg::REQ_WR_CPL: begin
        if (q.own_st < NUM_STATES && q.nbr_st < NUM_STATES)
          cpl_mdl[((q.dir * SITES + site) * NUM_STATES + q.own_st) * NUM_STATES
                  + q.nbr_st] = q.cpl;
      end
      default: ;
    endcase
    res.spin = lat_mdl[site];
    expected_results.push_back(res);
  endtask

  task automatic queue_req(pmsu_pkg::req_e k, int r, int c, int dir, int a, int b,
                           int cv, int sv, int fr);
    site_req_t q;
    q.kind = k;
    q.row = 6'(r);
    q.col = 6'(c);
    q.dir = 1'(dir);
    q.own_st = 3'(a);
    q.nbr_st = 3'(b);
    q.cpl = 16'(cv);
    q.spin = 3'(sv);
    q.frac = 16'(fr);
    pending_reqs.push_back(q);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) predict_site_update(cur_req);
      if (!(start_i && busy_o)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (!hold_off && pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          burst_left--;
          req_type_i <= cur_req.kind;
          row_i <= cur_req.row;
          col_i <= cur_req.col;
          bond_dir_i <= cur_req.dir;
          first_state_i <= cur_req.own_st;
          second_state_i <= cur_req.nbr_st;
          coupling_value_i <= cur_req.cpl;
          spin_value_i <= cur_req.spin;
          random_fraction_i <= cur_req.frac;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    site_res_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction acc=%0d spin=%0d", $time,
                 accepted_o, site_spin_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (accepted_o !== e.acc) begin
          $display("%0t: accepted expected %0d actual %0d", $time, e.acc, accepted_o);
          errors++;
        end
        if (site_spin_o !== e.spin) begin
          $display("%0t: site_spin expected %0d actual %0d", $time, e.spin, site_spin_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || start_i || busy_o);
    repeat (25) @(negedge clk_i);
  endtask

  task automatic set_beta(logic [15:0] v);
    wait_drained();
    hold_off = 1'b1;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pmsu_pkg::ADDR_BETA;
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    beta_mdl = v;
    @(negedge clk_i);
    hold_off = 1'b0;
  endtask

  task automatic queue_random(int n);
    int sel, sv, a, b, cv;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      sv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      cv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, 1023) - 512;
      if (sel < 60)
        queue_req(pmsu_pkg::REQ_TRIAL, trial_coord(), trial_coord(),
                  $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 65535), sv, $urandom_range(0, 65535));
      else if (sel < 72)
        queue_req(pmsu_pkg::REQ_WR_SPIN, win_coord(), win_coord(),
                  $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 65535), sv, $urandom_range(0, 65535));
      else if (sel < 88) begin
        a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
        b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
        queue_req(pmsu_pkg::REQ_WR_CPL, win_coord(), win_coord(),
                  $urandom_range(0, 1), a, b, cv, $urandom_range(0, 7),
                  $urandom_range(0, 65535));
      end else
        queue_req(pmsu_pkg::REQ_RD_SPIN, win_coord(), win_coord(),
                  $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 65535), $urandom_range(0, 7),
                  $urandom_range(0, 65535));
    end
  endtask

  initial begin
    logic [63:0] e, q;
    logic [15:0] betas [4];
    e = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      if (i > 0) e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
      q = (e + (64'd1 << 15)) >> 16;
      exp_q16[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    foreach (lat_mdl[i]) lat_mdl[i] = '0;
    foreach (cpl_mdl[i]) cpl_mdl[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // load the spins of rows/cols -1..4 and every bond that a trial in rows/cols
    // 0..3 reads, so that no request touches an unwritten entry
    for (int r = -1; r <= 4; r++)
      for (int c = -1; c <= 4; c++)
        queue_req(pmsu_pkg::REQ_WR_SPIN, (r + SIDE) % SIDE + SIDE * $urandom_range(0, 3),
                  (c + SIDE) % SIDE + SIDE * $urandom_range(0, 3), 0, 0, 0, 0,
                  $urandom_range(0, NUM_STATES - 1), 0);
    for (int d = 0; d < 2; d++)
      for (int r = -1; r < 4; r++)
        for (int c = -1; c < 4; c++)
          if ((d == 0) ? (c >= 0) : (r >= 0))
            for (int a = 0; a < NUM_STATES; a++)
              for (int b = 0; b < NUM_STATES; b++)
                queue_req(pmsu_pkg::REQ_WR_CPL, (r + SIDE) % SIDE, (c + SIDE) % SIDE,
                          d, a, b, $urandom_range(0, 1023) - 512, $urandom_range(0, 7),
                          $urandom_range(0, 65535));

    // directed: corners, wrap, ignored writes, bad proposals, extremes
    queue_req(pmsu_pkg::REQ_RD_SPIN, 63, 63, 1, 7, 7, 16'hFFFF, 7, 16'hFFFF);
    queue_req(pmsu_pkg::REQ_WR_SPIN, 0, 0, 0, 0, 0, 0, 2, 0);
    queue_req(pmsu_pkg::REQ_WR_SPIN, 0, 0, 0, 0, 0, 0, 7, 0);
    queue_req(pmsu_pkg::REQ_RD_SPIN, 16, 32, 0, 0, 0, 0, 0, 0);
    queue_req(pmsu_pkg::REQ_WR_CPL, 0, 0, 0, 7, 0, 16'h7FFF, 0, 0);
    queue_req(pmsu_pkg::REQ_WR_CPL, 0, 0, 1, 0, 3, 16'h8000, 0, 0);
    queue_req(pmsu_pkg::REQ_TRIAL, 0, 0, 0, 0, 0, 0, 2, 16'hFFFF);
    queue_req(pmsu_pkg::REQ_TRIAL, 0, 0, 0, 0, 0, 0, 5, 0);
    queue_req(pmsu_pkg::REQ_TRIAL, 19, 51, 0, 0, 0, 0, 0, 0);
    queue_req(pmsu_pkg::REQ_TRIAL, 48, 49, 0, 0, 0, 0, 1, 16'hFFFF);
    for (int a = 0; a < NUM_STATES; a++) begin
      queue_req(pmsu_pkg::REQ_WR_CPL, 0, 0, 0, a, 0, (a == 0) ? 16'h8000 : 16'h7FFF, 0, 0);
      queue_req(pmsu_pkg::REQ_WR_CPL, 0, 0, 0, a, 1, (a == 0) ? 16'h8000 : 16'h7FFF, 0, 0);
      queue_req(pmsu_pkg::REQ_WR_CPL, 0, 0, 0, a, 2, (a == 0) ? 16'h8000 : 16'h7FFF, 0, 0);
    end
    queue_req(pmsu_pkg::REQ_WR_SPIN, 0, 0, 0, 0, 0, 0, 1, 0);
    queue_req(pmsu_pkg::REQ_TRIAL, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
    queue_req(pmsu_pkg::REQ_TRIAL, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
    queue_req(pmsu_pkg::REQ_TRIAL, 0, 0, 0, 0, 0, 0, 2, 16'h0000);

    // beta sweep, block drained before each register write
    betas[0] = 16'd0;
    betas[1] = 16'hFFFF;
    betas[2] = 16'd1;
    betas[3] = 16'($urandom_range(0, 65535));
    queue_random(46);
    foreach (betas[i]) begin
      set_beta(betas[i]);
      queue_random(46);
    end
    wait_drained();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
